@@ design/tfp_pkg.sv @@
// Shared types, constants and CRC function for the telemetry frame parser.
package tfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 255;
  localparam int unsigned HDR_BYTES   = 10;
  localparam int unsigned MAX_LEN     = HDR_BYTES + MAX_PAYLOAD;
  localparam logic [7:0]  CRC_POLY    = 8'h07;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_SYNC    = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;

  localparam logic [7:0] SYNC_RST    = 8'd60;
  localparam logic [7:0] MASK_RST    = 8'd248;
  localparam logic [7:0] VERSION_RST = 8'd32;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_GOOD    = 2'd2;
  localparam logic [1:0] EV_BAD     = 2'd3;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] version_mask;
    logic [7:0] protocol_version;
  } tfp_cfg_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  message_kind;
    logic [8:0]  frame_length;
    logic [31:0] object_id;
    logic [15:0] instance_id;
  } tfp_result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

@@ design/tfp_if.sv @@
// Valid/ready channel interfaces for received bytes and parser results.
interface tfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface tfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  message_kind;
  logic [8:0]  frame_length;
  logic [31:0] object_id;
  logic [15:0] instance_id;

  modport source (output valid, output event_res, output payload_byte, output payload_index,
                  output message_kind, output frame_length, output object_id,
                  output instance_id, input ready);
  modport sink (input valid, input event_res, input payload_byte, input payload_index,
                input message_kind, input frame_length, input object_id,
                input instance_id, output ready);
endinterface

@@ design/tfp_regs.sv @@
// APB configuration registers of the telemetry frame parser.
module tfp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [tfp_pkg::DATA_W-1:0]   pwdata,
  output logic [tfp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output tfp_pkg::tfp_cfg_t            cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value       <= tfp_pkg::SYNC_RST;
      cfg.version_mask     <= tfp_pkg::MASK_RST;
      cfg.protocol_version <= tfp_pkg::VERSION_RST;
    end else if (wr_en) begin
      unique case (reg_index)
        tfp_pkg::REG_SYNC:    cfg.sync_value       <= pwdata[7:0];
        tfp_pkg::REG_MASK:    cfg.version_mask     <= pwdata[7:0];
        tfp_pkg::REG_VERSION: cfg.protocol_version <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      tfp_pkg::REG_SYNC:    prdata[7:0] = cfg.sync_value;
      tfp_pkg::REG_MASK:    prdata[7:0] = cfg.version_mask;
      tfp_pkg::REG_VERSION: prdata[7:0] = cfg.protocol_version;
      default:              prdata      = '0;
    endcase
  end

endmodule

@@ design/tfp_parser.sv @@
// Frame parse state, CRC-8 accumulation and per-byte result logic.
module tfp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            byte_in,
  input  tfp_pkg::tfp_cfg_t     cfg,
  output tfp_pkg::tfp_result_t  result
);

  typedef enum logic [2:0] {
    PH_WAIT_SYNC = 3'd0,
    PH_TYPE      = 3'd1,
    PH_LENGTH    = 3'd2,
    PH_OBJECT    = 3'd3,
    PH_INSTANCE  = 3'd4,
    PH_PAYLOAD   = 3'd5,
    PH_CHECK     = 3'd6
  } phase_t;

  localparam logic [8:0]  HDR_LEN  = 9'(tfp_pkg::HDR_BYTES);
  localparam logic [15:0] MIN_WORD = 16'(tfp_pkg::HDR_BYTES);
  localparam logic [15:0] MAX_WORD = 16'(tfp_pkg::MAX_LEN);

  phase_t      phase, phase_next;
  logic [7:0]  crc, crc_next;
  logic [7:0]  count, count_next;
  logic [7:0]  len_low, len_low_next;
  logic [8:0]  len, len_next;
  logic [7:0]  kind, kind_next;
  logic [31:0] obj, obj_next;
  logic [15:0] inst, inst_next;

  logic [7:0]  crc_step;
  logic [15:0] len_word;
  logic [8:0]  pay_len;
  logic [8:0]  count_inc;

  assign crc_step  = tfp_pkg::crc8_update(crc, byte_in);
  assign len_word  = {byte_in, len_low};
  assign pay_len   = len - HDR_LEN;
  assign count_inc = {1'b0, count} + 9'd1;

  always_comb begin
    phase_next   = phase;
    crc_next     = crc;
    count_next   = count;
    len_low_next = len_low;
    len_next     = len;
    kind_next    = kind;
    obj_next     = obj;
    inst_next    = inst;
    result       = '0;
    unique case (phase)
      PH_TYPE: begin
        crc_next = crc_step;
        if ((byte_in & cfg.version_mask) == cfg.protocol_version) begin
          kind_next  = byte_in;
          count_next = '0;
          phase_next = PH_LENGTH;
        end else begin
          phase_next = PH_WAIT_SYNC;
        end
      end
      PH_LENGTH: begin
        crc_next = crc_step;
        if (count == 8'd0) begin
          len_low_next = byte_in;
          count_next   = 8'd1;
        end else begin
          count_next = '0;
          len_next   = len_word[8:0];
          if (len_word < MIN_WORD || len_word > MAX_WORD) begin
            phase_next = PH_WAIT_SYNC;
          end else begin
            phase_next = PH_OBJECT;
          end
        end
      end
      PH_OBJECT: begin
        crc_next = crc_step;
        if (count == 8'd0) begin
          obj_next = {24'd0, byte_in};
        end else begin
          unique case (count[1:0])
            2'd1:    obj_next[15:8]  = byte_in;
            2'd2:    obj_next[23:16] = byte_in;
            2'd3:    obj_next[31:24] = byte_in;
            default: obj_next[7:0]   = byte_in;
          endcase
        end
        if (count_inc >= 9'd4) begin
          count_next = '0;
          phase_next = PH_INSTANCE;
        end else begin
          count_next = count_inc[7:0];
        end
      end
      PH_INSTANCE: begin
        crc_next = crc_step;
        if (count == 8'd0) begin
          inst_next  = {8'd0, byte_in};
          count_next = 8'd1;
        end else begin
          inst_next[15:8] = byte_in;
          count_next      = '0;
          phase_next      = (len == HDR_LEN) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_next             = crc_step;
        result.event_res     = tfp_pkg::EV_PAYLOAD;
        result.payload_byte  = byte_in;
        result.payload_index = count;
        result.message_kind  = kind;
        result.frame_length  = len;
        result.object_id     = obj;
        result.instance_id   = inst;
        if (count_inc >= pay_len) begin
          count_next = '0;
          phase_next = PH_CHECK;
        end else begin
          count_next = count_inc[7:0];
        end
      end
      PH_CHECK: begin
        result.event_res    = (byte_in == crc) ? tfp_pkg::EV_GOOD : tfp_pkg::EV_BAD;
        result.message_kind = kind;
        result.frame_length = len;
        result.object_id    = obj;
        result.instance_id  = inst;
        phase_next          = PH_WAIT_SYNC;
      end
      default: begin
        phase_next = PH_WAIT_SYNC;
        if (byte_in == cfg.sync_value) begin
          crc_next   = tfp_pkg::crc8_update(8'd0, byte_in);
          phase_next = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_WAIT_SYNC;
      crc     <= '0;
      count   <= '0;
      len_low <= '0;
      len     <= '0;
      kind    <= '0;
      obj     <= '0;
      inst    <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      crc     <= crc_next;
      count   <= count_next;
      len_low <= len_low_next;
      len     <= len_next;
      kind    <= kind_next;
      obj     <= obj_next;
      inst    <= inst_next;
    end
  end

endmodule

@@ design/telemetry_frame_parser_crc8_top.sv @@
// Top level of the telemetry frame parser with CRC-8 check.
//
// Channel rx carries one received link byte per request; channel result
// returns exactly one result per byte, in order: nothing, a payload byte
// with its index, or a good or bad frame event with the frame's fields.
// Fields with no meaning for an event read as zero.
// Configuration (sync value, version mask, protocol version) is written
// over the APB port at byte addresses 0, 4 and 8; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A byte is held in an input register, then parsed in one pass into the
// result register; one byte is accepted every cycle while results are taken.
// When the receiver stalls, the result register holds and the input
// register fills; rx.ready then drops until the result is taken.
// Reset empties both registers, returns the parser to the sync hunt and
// restores the register defaults.
module telemetry_frame_parser_crc8_top (
  input  logic                        clk,
  input  logic                        rst,
  tfp_byte_if.sink                    rx,
  tfp_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [tfp_pkg::DATA_W-1:0]  pwdata,
  output logic [tfp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  tfp_pkg::tfp_cfg_t    cfg;
  tfp_pkg::tfp_result_t parsed;
  tfp_pkg::tfp_result_t res_reg;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       advance;

  assign advance  = in_valid && (!out_valid || result.ready);
  assign rx.ready = !in_valid || advance;

  tfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (in_byte),
    .cfg     (cfg),
    .result  (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= parsed;
    end
  end

  assign result.valid         = out_valid;
  assign result.event_res     = res_reg.event_res;
  assign result.payload_byte  = res_reg.payload_byte;
  assign result.payload_index = res_reg.payload_index;
  assign result.message_kind  = res_reg.message_kind;
  assign result.frame_length  = res_reg.frame_length;
  assign result.object_id     = res_reg.object_id;
  assign result.instance_id   = res_reg.instance_id;

endmodule

@@ design/tfp_checker.sv @@
// Port-level assertions for the telemetry frame parser, bound to the top level.
module tfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_res,
  input logic [7:0]  payload_byte,
  input logic [7:0]  payload_index,
  input logic [7:0]  message_kind,
  input logic [8:0]  frame_length,
  input logic [31:0] object_id,
  input logic [15:0] instance_id
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(payload_byte))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == tfp_pkg::EV_NONE |->
      payload_byte == 8'd0 && payload_index == 8'd0 && message_kind == 8'd0 &&
      frame_length == 9'd0 && object_id == 32'd0 && instance_id == 16'd0)
    else $error("idle result carries data");

  a_frame_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == tfp_pkg::EV_GOOD || event_res == tfp_pkg::EV_BAD) |->
      payload_byte == 8'd0 && payload_index == 8'd0 &&
      frame_length >= 9'(tfp_pkg::HDR_BYTES))
    else $error("frame event fields out of range");

  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == tfp_pkg::EV_PAYLOAD |->
      frame_length > 9'(tfp_pkg::HDR_BYTES) &&
      {1'b0, payload_index} < frame_length - 9'(tfp_pkg::HDR_BYTES))
    else $error("payload index beyond frame length");

endmodule

bind telemetry_frame_parser_crc8_top tfp_checker u_tfp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .event_res     (result.event_res),
  .payload_byte  (result.payload_byte),
  .payload_index (result.payload_index),
  .message_kind  (result.message_kind),
  .frame_length  (result.frame_length),
  .object_id     (result.object_id),
  .instance_id   (result.instance_id)
);
